// ===== hdl/vpe_pkg.sv =====
// shared types, codes and constants of the wavetable/pcm voice engine
`timescale 1ns / 1ps
`default_nettype none
package vpe_pkg;

  // table memories
  localparam int TABLE_BYTES = 4096;
  localparam int TABLE_AW    = 12;

  // item modes
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_STEP  = 2'd2,
    MODE_NONE  = 2'd3
  } vpe_mode_e;

  // voice register byte offsets
  localparam logic [2:0] REG_FLAGS = 3'd0;
  localparam logic [2:0] REG_VOL   = 3'd1;
  localparam logic [2:0] REG_PLO   = 3'd2;
  localparam logic [2:0] REG_PHI   = 3'd3;
  localparam logic [2:0] REG_START = 3'd4;
  localparam logic [2:0] REG_END   = 3'd5;

  // flag bits of the stored voice flags
  localparam int FLAG_KEY     = 0;
  localparam int FLAG_WAVE    = 1;
  localparam int FLAG_ONESHOT = 2;
  localparam int FLAG_DIV     = 3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [12:0]       address;
    logic [7:0]        write_data;
    logic [3:0]        voice_index;
    logic signed [7:0] pcm_sample;
  } vpe_in_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic signed [11:0] voice_left;
    logic signed [11:0] voice_right;
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic [19:0]        fetch_address;
    logic               voice_active;
  } vpe_out_t;

  // one entry of the voice memory
  typedef struct packed {
    logic [3:0]  flags;
    logic [7:0]  vol;
    logic [15:0] pitch;
    logic [7:0]  start;
    logic [7:0]  endv;
    logic [25:0] phase;
    logic [17:0] envph;
  } vpe_voice_t;

  // item as it travels down the pipeline
  typedef struct packed {
    vpe_in_t    item;
    logic [3:0] op_voice;
    logic       wr_voice;
  } vpe_op_t;

  // saturate a 17-bit sum to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [16:0] s);
    logic signed [15:0] r;
    if (s > 17'sd32767) begin
      r = 16'sh7fff;
    end else if (s < -17'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/vpe_table_ram.sv =====
// single-port 4096 x 8 table memory, read-first, registered read data
`timescale 1ns / 1ps
`default_nettype none
module vpe_table_ram (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic                         we_i,
  input  wire logic [vpe_pkg::TABLE_AW-1:0] addr_i,
  input  wire logic [7:0]                   wdata_i,
  output logic      [7:0]                   rdata_o
);

  logic [7:0] mem [vpe_pkg::TABLE_BYTES];
  logic [7:0] rdata_q;

  // read and write port
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/vpe_voice_mem.sv =====
// voice state memory: two read ports, one write port, per-entry valid bits
`timescale 1ns / 1ps
`default_nettype none
module vpe_voice_mem #(
  parameter int VOICE_COUNT = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rd_en_i,
  input  wire logic [3:0]         rd0_idx_i,
  input  wire logic [3:0]         rd1_idx_i,
  output vpe_pkg::vpe_voice_t     rd0_data_o,
  output vpe_pkg::vpe_voice_t     rd1_data_o,
  input  wire logic               we_i,
  input  wire logic [3:0]         wr_idx_i,
  input  wire vpe_pkg::vpe_voice_t wr_data_i
);

  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  vpe_pkg::vpe_voice_t    mem [VOICE_COUNT];
  vpe_pkg::vpe_voice_t    d0_q, d1_q;
  logic [VOICE_COUNT-1:0] vld_q;
  logic                   v0_q, v1_q;
  logic                   ok0, ok1, okw;

  assign ok0 = ({1'b0, rd0_idx_i} < 5'(VOICE_COUNT));
  assign ok1 = ({1'b0, rd1_idx_i} < 5'(VOICE_COUNT));
  assign okw = ({1'b0, wr_idx_i} < 5'(VOICE_COUNT));

  // storage, read-first
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      d0_q <= mem[rd0_idx_i[VW-1:0]];
      d1_q <= mem[rd1_idx_i[VW-1:0]];
    end
    if (we_i && okw) begin
      mem[wr_idx_i[VW-1:0]] <= wr_data_i;
    end
  end

  // valid bits, an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
    end else begin
      if (rd_en_i) begin
        v0_q <= ok0 && vld_q[rd0_idx_i[VW-1:0]];
        v1_q <= ok1 && vld_q[rd1_idx_i[VW-1:0]];
      end
      if (we_i && okw) begin
        vld_q[wr_idx_i[VW-1:0]] <= 1'b1;
      end
    end
  end

  assign rd0_data_o = v0_q ? d0_q : '0;
  assign rd1_data_o = v1_q ? d1_q : '0;

endmodule
`default_nettype wire

// ===== hdl/vpe_voice_update.sv =====
// per-item compute: voice register access, voice step, mix and result item
`timescale 1ns / 1ps
`default_nettype none
module vpe_voice_update (
  input  wire vpe_pkg::vpe_op_t     op_i,
  input  wire logic                 op_ok_i,
  input  wire logic                 rep_ok_i,
  input  wire vpe_pkg::vpe_voice_t  cur_i,
  input  wire vpe_pkg::vpe_voice_t  rep_i,
  input  wire logic [7:0]           env_rd_i,
  input  wire logic [7:0]           wave_rd_i,
  input  wire logic signed [15:0]   mix_l_i,
  input  wire logic signed [15:0]   mix_r_i,
  output vpe_pkg::vpe_voice_t       nxt_o,
  output logic                      we_o,
  output logic                      mix_we_o,
  output vpe_pkg::vpe_out_t         out_o
);

  always_comb begin
    vpe_pkg::vpe_voice_t nxt, rv;
    logic               we, is_reg;
    logic [12:0]        a;
    logic [7:0]         d;
    logic [3:0]         vl, vr;
    logic signed [7:0]  smp;
    logic [17:0]        env_sum;
    logic [16:0]        inc17;
    logic [17:0]        ph18;
    logic [8:0]         inc9;
    logic [25:0]        ph26;
    logic signed [12:0] pl, pr;
    logic signed [11:0] l, r;
    logic signed [15:0] ml, mr;

    nxt     = cur_i;
    we      = 1'b0;
    a       = op_i.item.address;
    d       = op_i.item.write_data;
    is_reg  = !a[12] && (a[11:7] == 5'd0);
    vl      = 4'd0;
    vr      = 4'd0;
    smp     = 8'sd0;
    env_sum = '0;
    inc17   = '0;
    ph18    = '0;
    inc9    = '0;
    ph26    = '0;
    out_o   = '0;
    mix_we_o = 1'b0;

    // bus read
    if (op_i.item.mode == vpe_pkg::MODE_READ) begin
      if (a[12]) begin
        out_o.read_data = wave_rd_i;
      end else if (!is_reg) begin
        out_o.read_data = env_rd_i;
      end else if (op_ok_i) begin
        case (a[2:0])
          vpe_pkg::REG_FLAGS: out_o.read_data = {cur_i.flags[vpe_pkg::FLAG_DIV], 4'd0,
                                                 cur_i.flags[2:0]};
          vpe_pkg::REG_VOL:   out_o.read_data = cur_i.vol;
          vpe_pkg::REG_PLO:   out_o.read_data = cur_i.pitch[7:0];
          vpe_pkg::REG_PHI:   out_o.read_data = cur_i.pitch[15:8];
          vpe_pkg::REG_START: out_o.read_data = cur_i.start;
          vpe_pkg::REG_END:   out_o.read_data = cur_i.endv;
          default:            out_o.read_data = 8'd0;
        endcase
      end
    end

    // bus write to a voice register
    if (op_i.item.mode == vpe_pkg::MODE_WRITE && is_reg && op_ok_i) begin
      we = 1'b1;
      case (a[2:0])
        vpe_pkg::REG_FLAGS: begin
          nxt.flags = {d[7], d[2:0]};
          if (!cur_i.flags[vpe_pkg::FLAG_KEY] && d[0]) begin
            nxt.phase = d[1] ? 26'd0 : {2'b00, cur_i.start, 16'h0000};
            nxt.envph = '0;
          end
        end
        vpe_pkg::REG_VOL:   nxt.vol = d;
        vpe_pkg::REG_PLO:   nxt.pitch[7:0] = d;
        vpe_pkg::REG_PHI:   nxt.pitch[15:8] = d;
        vpe_pkg::REG_START: nxt.start = d;
        vpe_pkg::REG_END:   nxt.endv = d;
        default:            we = 1'b0;
      endcase
    end

    // voice step
    if (op_i.item.mode == vpe_pkg::MODE_STEP && op_ok_i) begin
      mix_we_o = 1'b1;
      if (cur_i.flags[vpe_pkg::FLAG_KEY]) begin
        we = 1'b1;
        if (cur_i.flags[vpe_pkg::FLAG_WAVE]) begin
          vl      = env_rd_i[7:4];
          vr      = env_rd_i[3:0];
          env_sum = cur_i.envph + {10'd0, cur_i.start};
          if (cur_i.flags[vpe_pkg::FLAG_ONESHOT] && env_sum[17]) begin
            nxt.flags[vpe_pkg::FLAG_KEY] = 1'b0;
            nxt.envph = env_sum;
          end else begin
            nxt.envph = {1'b0, env_sum[16:0]};
          end
          smp   = $signed(wave_rd_i);
          inc17 = cur_i.flags[vpe_pkg::FLAG_DIV] ? {1'b0, cur_i.pitch}
                                                 : {cur_i.pitch, 1'b0};
          ph18  = cur_i.phase[17:0] + {1'b0, inc17};
          nxt.phase = {8'd0, ph18};
        end else begin
          vl   = cur_i.vol[7:4];
          vr   = cur_i.vol[3:0];
          smp  = op_i.item.pcm_sample;
          inc9 = cur_i.flags[vpe_pkg::FLAG_DIV] ? {1'b0, cur_i.pitch[7:0]}
                                                : {cur_i.pitch[7:0], 1'b0};
          ph26 = cur_i.phase + {17'd0, inc9};
          nxt.phase = ph26;
          if (ph26[25:17] > {1'b0, ~cur_i.endv}) begin
            nxt.flags[vpe_pkg::FLAG_KEY] = 1'b0;
          end
        end
      end
    end

    // products and mix
    pl = smp * $signed({1'b0, vl});
    pr = smp * $signed({1'b0, vr});
    l  = pl[11:0];
    r  = pr[11:0];
    ml = mix_l_i;
    mr = mix_r_i;
    if (mix_we_o) begin
      if (op_i.item.voice_index == 4'd0) begin
        ml = 16'(l);
        mr = 16'(r);
      end else begin
        ml = vpe_pkg::sat16(17'(mix_l_i) + 17'(l));
        mr = vpe_pkg::sat16(17'(mix_r_i) + 17'(r));
      end
    end
    out_o.voice_left  = l;
    out_o.voice_right = r;
    out_o.mix_left    = ml;
    out_o.mix_right   = mr;

    // reported voice, seen after this item's update
    rv = (we && op_i.op_voice == op_i.item.voice_index) ? nxt : rep_i;
    if (rep_ok_i) begin
      out_o.fetch_address = rv.phase[24:5];
      out_o.voice_active  = rv.flags[vpe_pkg::FLAG_KEY];
    end

    nxt_o = nxt;
    we_o  = we;
  end

endmodule
`default_nettype wire

// ===== hdl/wavetable_pcm_voice_engine.sv =====
// An accepted item passes the a, b and c stages and leaves as a result item from o.
// Throughput: one item per cycle while the output is not stalled and no item
// needs a voice that an item ahead of it still writes back; such an item waits
// for that write-back to the voice memory (read, compute, write).
// Reset: voice state reads as zero at once; both 4096-byte table memories are
// cleared one byte per cycle, and no item is accepted until the clearing ends.
`timescale 1ns / 1ps
`default_nettype none
module wavetable_pcm_voice_engine #(
  parameter int VOICE_COUNT = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire vpe_pkg::vpe_in_t  in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output vpe_pkg::vpe_out_t      out_item_o
);

  // pipeline registers
  logic                    a_valid_q, b_valid_q, c_valid_q, o_valid_q;
  vpe_pkg::vpe_op_t        a_q, b_q, c_q, in_op;
  vpe_pkg::vpe_voice_t     c_cur_q, c_rep_q;
  vpe_pkg::vpe_out_t       o_q;
  logic signed [15:0]      mix_l_q, mix_r_q;
  logic                    clr_busy_q;
  logic [vpe_pkg::TABLE_AW-1:0] clr_cnt_q;

  logic move, hazard, a_adv, in_acc, conf_b, conf_c;
  vpe_pkg::vpe_voice_t vm_rd0, vm_rd1, upd_nxt;
  logic                upd_we, upd_mix_we, vm_we;
  vpe_pkg::vpe_out_t   upd_out;
  logic [7:0]          env_rd, wave_rd;
  logic [vpe_pkg::TABLE_AW-1:0] env_addr, wave_addr;
  logic env_we, wave_we, tab_en, b_is_step, b_is_wr;
  logic c_op_ok, c_rep_ok;

  // decode of an incoming item
  always_comb begin
    in_op.item     = in_item_i;
    in_op.op_voice = (in_item_i.mode == vpe_pkg::MODE_STEP) ? in_item_i.voice_index
                                                             : in_item_i.address[6:3];
    in_op.wr_voice = (in_item_i.mode == vpe_pkg::MODE_STEP) ||
                     (in_item_i.mode == vpe_pkg::MODE_WRITE && !in_item_i.address[12] &&
                      in_item_i.address[11:7] == 5'd0);
  end

  // interlock against pending voice write-backs
  assign conf_b = b_valid_q && b_q.wr_voice &&
                  (b_q.op_voice == a_q.op_voice || b_q.op_voice == a_q.item.voice_index);
  assign conf_c = c_valid_q && c_q.wr_voice &&
                  (c_q.op_voice == a_q.op_voice || c_q.op_voice == a_q.item.voice_index);
  assign hazard = conf_b || conf_c;
  assign move   = !o_valid_q || !out_stall_i;
  assign a_adv  = a_valid_q && move && !hazard;
  assign in_stall_o = clr_busy_q || (a_valid_q && !a_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      mix_l_q   <= '0;
      mix_r_q   <= '0;
    end else begin
      if (in_acc) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (move) begin
        b_valid_q <= a_adv;
        c_valid_q <= b_valid_q;
        o_valid_q <= c_valid_q;
        if (c_valid_q && upd_mix_we) begin
          mix_l_q <= upd_out.mix_left;
          mix_r_q <= upd_out.mix_right;
        end
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q <= in_op;
    end
    if (move) begin
      b_q     <= a_q;
      c_q     <= b_q;
      c_cur_q <= vm_rd0;
      c_rep_q <= vm_rd1;
      o_q     <= upd_out;
    end
  end

  // table clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // voice memory: read as the item enters, write back as it leaves
  assign vm_we = move && c_valid_q && upd_we;

  vpe_voice_mem #(
    .VOICE_COUNT(VOICE_COUNT)
  ) u_voice_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (a_adv),
    .rd0_idx_i (a_q.op_voice),
    .rd1_idx_i (a_q.item.voice_index),
    .rd0_data_o(vm_rd0),
    .rd1_data_o(vm_rd1),
    .we_i      (vm_we),
    .wr_idx_i  (c_q.op_voice),
    .wr_data_i (upd_nxt)
  );

  // table addresses: clear counter while clearing, voice state read for a step item, else the bus address
  assign b_is_step = b_q.item.mode == vpe_pkg::MODE_STEP;
  assign b_is_wr   = b_valid_q && b_q.item.mode == vpe_pkg::MODE_WRITE;
  always_comb begin
    if (clr_busy_q) begin
      env_addr  = clr_cnt_q;
      wave_addr = clr_cnt_q;
    end else if (b_is_step) begin
      env_addr  = {vm_rd0.endv[4:0], vm_rd0.envph[16:10]};
      wave_addr = {vm_rd0.vol[4:0], vm_rd0.phase[17:11]};
    end else begin
      env_addr  = b_q.item.address[11:0];
      wave_addr = b_q.item.address[11:0];
    end
  end
  assign tab_en  = clr_busy_q || move;
  assign env_we  = clr_busy_q || (move && b_is_wr && !b_q.item.address[12] &&
                                  b_q.item.address[11:7] != 5'd0);
  assign wave_we = clr_busy_q || (move && b_is_wr && b_q.item.address[12]);

  vpe_table_ram u_env_ram (
    .clk_i  (clk_i),
    .en_i   (tab_en),
    .we_i   (env_we),
    .addr_i (env_addr),
    .wdata_i(clr_busy_q ? 8'd0 : b_q.item.write_data),
    .rdata_o(env_rd)
  );

  vpe_table_ram u_wave_ram (
    .clk_i  (clk_i),
    .en_i   (tab_en),
    .we_i   (wave_we),
    .addr_i (wave_addr),
    .wdata_i(clr_busy_q ? 8'd0 : b_q.item.write_data),
    .rdata_o(wave_rd)
  );

  // compute stage
  assign c_op_ok  = ({1'b0, c_q.op_voice} < 5'(VOICE_COUNT));
  assign c_rep_ok = ({1'b0, c_q.item.voice_index} < 5'(VOICE_COUNT));

  vpe_voice_update u_update (
    .op_i     (c_q),
    .op_ok_i  (c_op_ok),
    .rep_ok_i (c_rep_ok),
    .cur_i    (c_cur_q),
    .rep_i    (c_rep_q),
    .env_rd_i (env_rd),
    .wave_rd_i(wave_rd),
    .mix_l_i  (mix_l_q),
    .mix_r_i  (mix_r_q),
    .nxt_o    (upd_nxt),
    .we_o     (upd_we),
    .mix_we_o (upd_mix_we),
    .out_o    (upd_out)
  );

  assign out_valid_o = o_valid_q;
  assign out_item_o  = o_q;

  // no item enters while the tables are being cleared
  a_clr_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> in_stall_o)
    else $error("item accepted during table clear");

  // a voice write-back never races the read of an item entering the pipeline
  a_no_stale_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vm_we && a_adv) |-> (c_q.op_voice != a_q.op_voice &&
                          c_q.op_voice != a_q.item.voice_index))
    else $error("voice read overlaps pending write-back");

  // the clearing pass ends only after the last table byte
  a_clr_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> $past(&clr_cnt_q))
    else $error("table clear ended early");

  // the pipeline holds no item while clearing
  a_clr_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !(a_valid_q || b_valid_q || c_valid_q))
    else $error("item in flight during table clear");

endmodule
`default_nettype wire
